// ===== design/owsrch_pkg.sv =====
// Shared types and constants for the 1-Wire device code search engine.
`timescale 1ns / 1ps
package owsrch_pkg;

  // Default for the pass limit of one enumeration
  localparam int unsigned MAX_PASSES_DEF = 255;

  localparam int unsigned CODE_BITS = 64;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [POS_W-1:0] START_MARK = 7'd65;
  localparam logic [POS_W-1:0] FULL_POS   = 7'd64;

  // Reset values of the configuration registers and the saturation value of the found count
  localparam logic [BYTE_W-1:0] SEARCH_CMD_RST = 8'd240;
  localparam logic [BYTE_W-1:0] DEV_LIMIT_RST  = 8'd20;
  localparam logic [BYTE_W-1:0] COUNT_MAX      = 8'hff;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SEARCH_COMMAND = 1'b0,
    REG_DEVICE_LIMIT   = 1'b1
  } reg_idx_e;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PASS  = 2'd1,
    OP_BIT   = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DIR  = 2'd1,
    KIND_CODE = 2'd2,
    KIND_DONE = 2'd3
  } kind_e;

  // One result beat as held in the output queue
  typedef struct packed {
    logic                 last;
    kind_e                kind;
    logic [BYTE_W-1:0]    cmd;
    logic                 dir;
    logic [CODE_BITS-1:0] code;
    logic [BYTE_W-1:0]    count;
    logic                 err;
  } res_t;

  localparam int unsigned RES_PER_ITEM = 3;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = 2;
  localparam int unsigned QCNT_W       = 3;

  // Build one result beat; last is filled in later
  function automatic res_t mk_res(kind_e kind, logic [BYTE_W-1:0] cmd, logic dir,
                                  logic [CODE_BITS-1:0] code,
                                  logic [BYTE_W-1:0] count, logic err);
    res_t r;
    r.last  = 1'b0;
    r.kind  = kind;
    r.cmd   = cmd;
    r.dir   = dir;
    r.code  = code;
    r.count = count;
    r.err   = err;
    return r;
  endfunction

endpackage

// ===== design/onewire_rom_search_engine_top.sv =====
// Top level of the 1-Wire device code search engine.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready       | tuser opcode, tdata bit pair/presence
//  m_axis   | out | m_axis_tvalid/tready       | tuser kind, tdata result, tlast
//  cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// An input beat updates the search state in the cycle it is accepted and pushes
// zero to three result beats into a four-entry output queue; results leave at
// one beat per cycle while m_axis_tready is high. A new input beat is taken every
// cycle while the queue holds at most one result, so one item per cycle when
// results are drained. Reset is asynchronous, active low; the config port never stalls.
`timescale 1ns / 1ps
module onewire_rom_search_engine_top
  import owsrch_pkg::*;
#(
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  logic [7:0]  s_axis_tdata,   // [0] presence, [1] id_bit, [2] complement_bit
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic [87:0] m_axis_tdata,   // [7:0] command_byte, [8] direction_bit,
                                      // [72:9] rom_code, [80:73] found_count,
                                      // [81] bus_error, [87:82] zero
  output logic        m_axis_tlast,   // last_of_run
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned PASS_W = $clog2(MAX_PASSES + 1);
  localparam logic [PASS_W-1:0] PASS_LIMIT = PASS_W'(MAX_PASSES);

  // Configuration registers
  logic [BYTE_W-1:0] search_cmd_q, dev_limit_q;

  // Search state
  logic [CODE_BITS-1:0] prev_code_q, prev_code_d;
  logic [CODE_BITS-1:0] asm_code_q, asm_code_d;
  logic [POS_W-1:0]     mark_q, mark_d;
  logic [POS_W-1:0]     next_mark_q, next_mark_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [BYTE_W-1:0]    found_q, found_d;
  logic [PASS_W-1:0]    passes_q, passes_d;
  logic                 active_q, active_d;

  // Output queue
  res_t               queue_q [QDEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  res_t               res [RES_PER_ITEM];
  logic [1:0]         nres;

  logic in_fire, out_fire;
  logic in_range;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (cnt_q <= QCNT_W'(1));
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;
  assign in_range      = (pos_q != '0) && (pos_q <= FULL_POS);

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_cmd_q <= SEARCH_CMD_RST;
      dev_limit_q  <= DEV_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SEARCH_COMMAND: search_cmd_q <= cfg_data_i;
        REG_DEVICE_LIMIT:   dev_limit_q  <= cfg_data_i;
      endcase
    end
  end

  // Search step: next state and the results of the accepted beat
  always_comb begin
    logic [IDX_W-1:0]     idx;
    logic                 b;
    logic                 done;
    logic [CODE_BITS-1:0] asm_new;
    logic [BYTE_W-1:0]    found_new;
    logic [PASS_W-1:0]    pass_new;

    prev_code_d = prev_code_q;
    asm_code_d  = asm_code_q;
    mark_d      = mark_q;
    next_mark_d = next_mark_q;
    pos_d       = pos_q;
    found_d     = found_q;
    passes_d    = passes_q;
    active_d    = active_q;
    nres        = 2'd0;
    for (int k = 0; k < RES_PER_ITEM; k++) res[k] = '0;

    idx       = IDX_W'(FULL_POS - pos_q);
    b         = s_axis_tdata[1];
    done      = 1'b0;
    asm_new   = asm_code_q;
    found_new = found_q;
    pass_new  = passes_q;

    if (in_fire) begin
      case (s_axis_tuser)
        OP_BEGIN: begin
          found_d     = '0;
          passes_d    = '0;
          prev_code_d = '0;
          asm_code_d  = '0;
          mark_d      = START_MARK;
          next_mark_d = '0;
          pos_d       = '0;
          active_d    = 1'b1;
        end
        OP_PASS: begin
          if (active_q) begin
            nres = 2'd1;
            if (!s_axis_tdata[0]) begin
              active_d = 1'b0;
              pos_d    = '0;
              res[0]   = mk_res(KIND_DONE, '0, 1'b0, '0, found_q, 1'b1);
            end else begin
              asm_code_d  = '0;
              next_mark_d = '0;
              pos_d       = FULL_POS;
              res[0]      = mk_res(KIND_CMD, search_cmd_q, 1'b0, '0, found_q, 1'b0);
            end
          end
        end
        OP_BIT: begin
          if (active_q && in_range) begin
            nres = 2'd1;
            if (s_axis_tdata[1] && s_axis_tdata[2]) begin
              // both slots high: nobody answered
              prev_code_d = '0;
              active_d    = 1'b0;
              pos_d       = '0;
              res[0]      = mk_res(KIND_DONE, '0, 1'b0, '0, found_q, 1'b1);
            end else begin
              // collision: take the one branch unless it was explored
              if (!s_axis_tdata[1] && !s_axis_tdata[2]) begin
                if ((mark_q > pos_q) || (prev_code_q[idx] && (mark_q != pos_q))) begin
                  b           = 1'b1;
                  next_mark_d = pos_q;
                end else begin
                  b = 1'b0;
                end
              end
              asm_new    = asm_code_q | (CODE_BITS'(b) << idx);
              asm_code_d = asm_new;
              pos_d      = pos_q - POS_W'(1);
              res[0]     = mk_res(KIND_DIR, '0, b, '0, found_q, 1'b0);

              // end of pass
              if (pos_q == POS_W'(1)) begin
                prev_code_d = asm_new;
                mark_d      = next_mark_d;
                if (passes_q < PASS_LIMIT) pass_new = passes_q + PASS_W'(1);
                passes_d = pass_new;
                if (asm_new[7:0] != '0) begin
                  if (found_q != COUNT_MAX) found_new = found_q + BYTE_W'(1);
                  res[1] = mk_res(KIND_CODE, '0, 1'b0, asm_new, found_new, 1'b0);
                  nres   = 2'd2;
                  if (found_new >= dev_limit_q) done = 1'b1;
                end
                found_d = found_new;
                if ((next_mark_d == '0) || (pass_new >= PASS_LIMIT)) done = 1'b1;
                if (done) begin
                  active_d = 1'b0;
                  if (nres == 2'd2) begin
                    res[2] = mk_res(KIND_DONE, '0, 1'b0, '0, found_new, 1'b0);
                    nres   = 2'd3;
                  end else begin
                    res[1] = mk_res(KIND_DONE, '0, 1'b0, '0, found_new, 1'b0);
                    nres   = 2'd2;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    // mark the final beat of this item
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      res[k].last = (32'(k) + 32'd1 == 32'(nres));
    end
  end

  // Search state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q <= '0;
      asm_code_q  <= '0;
      mark_q      <= START_MARK;
      next_mark_q <= '0;
      pos_q       <= FULL_POS;
      found_q     <= '0;
      passes_q    <= '0;
      active_q    <= 1'b0;
    end else begin
      prev_code_q <= prev_code_d;
      asm_code_q  <= asm_code_d;
      mark_q      <= mark_d;
      next_mark_q <= next_mark_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      passes_q    <= passes_d;
      active_q    <= active_d;
    end
  end

  // Queue storage: up to three beats written per cycle
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      if (32'(k) < 32'(nres)) queue_q[wptr_q + QPTR_W'(k)] <= res[k];
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QPTR_W'(nres);
      if (out_fire) rptr_q <= rptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(nres) - QCNT_W'(out_fire);
    end
  end

  // Result beat at the queue head
  res_t head;
  assign head          = queue_q[rptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {6'd0, head.err, head.count, head.code, head.dir, head.cmd};

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FULL_POS)
    else $error("bit position out of range");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    passes_q <= PASS_LIMIT)
    else $error("pass count beyond limit");

  a_bit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser == OP_BIT) && active_q && in_range) |=> (cnt_q != '0))
    else $error("bit pair gave no result");

endmodule

// ===== tb/tb_onewire_rom_search_engine_top.sv =====
// Self-checking testbench for the 1-Wire device code search engine top level.
`timescale 1ns / 1ps
module tb_onewire_rom_search_engine_top;
  import owsrch_pkg::*;

  // Opcode value the engine must ignore
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned SEG_ITEMS  = 60;
  localparam int unsigned DRAIN_CYC  = 12;
  localparam int unsigned HOLD_CYC   = 240;
  localparam int unsigned TIMEOUT_NS = 3_000_000;

  // One expected result beat
  typedef struct {
    kind_e       kind;
    logic [7:0]  cmd;
    logic        dir;
    logic [63:0] code;
    logic [7:0]  count;
    logic        err;
    logic        last;
  } search_beat_t;

  // Search state mirror plus the queue of result beats still owed by the engine
  class search_scoreboard;
    logic [7:0]   cmd_reg, limit_reg;
    logic [63:0]  prev_code, work_code;
    logic [6:0]   mark, next_mark, pos_left;
    logic [7:0]   found, passes;
    logic         active;
    search_beat_t owed_q[$];
    int unsigned  errors, items, beats, codes, aborts;

    function new();
      cmd_reg   = SEARCH_CMD_RST;
      limit_reg = DEV_LIMIT_RST;
      prev_code = '0;
      work_code = '0;
      mark      = START_MARK;
      next_mark = '0;
      pos_left  = FULL_POS;
      found     = '0;
      passes    = '0;
      active    = 1'b0;
      errors    = 0;
      items     = 0;
      beats     = 0;
      codes     = 0;
      aborts    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [7:0] value);
      case (idx)
        REG_SEARCH_COMMAND: cmd_reg = value;
        REG_DEVICE_LIMIT:   limit_reg = value;
        default: ;
      endcase
    endfunction

    function void owe(kind_e kind, logic [7:0] cmd, logic dir, logic [63:0] code, logic err);
      search_beat_t b;
      b.kind  = kind;
      b.cmd   = cmd;
      b.dir   = dir;
      b.code  = code;
      b.count = found;
      b.err   = err;
      b.last  = 1'b0;
      owed_q.push_back(b);
    endfunction

    // Advance the search by one accepted input beat; returns the chosen direction
    function logic note_input(logic [1:0] op, logic pres, logic idb, logic cmpb);
      int unsigned n_before;
      logic        b;
      logic        stop;
      logic [6:0]  offs;
      logic [5:0]  idx;
      n_before = owed_q.size();
      b        = idb;
      stop     = 1'b0;
      items++;
      if (op == OP_BEGIN) begin
        found     = '0;
        passes    = '0;
        prev_code = '0;
        work_code = '0;
        mark      = START_MARK;
        next_mark = '0;
        pos_left  = '0;
        active    = 1'b1;
      end else if (active && op != OP_UNUSED) begin
        if (op == OP_PASS) begin
          if (!pres) begin
            active   = 1'b0;
            pos_left = '0;
            aborts++;
            owe(KIND_DONE, 8'd0, 1'b0, 64'd0, 1'b1);
          end else begin
            work_code = '0;
            next_mark = '0;
            pos_left  = FULL_POS;
            owe(KIND_CMD, cmd_reg, 1'b0, 64'd0, 1'b0);
          end
        end else if (pos_left != 0 && pos_left <= FULL_POS) begin
          offs = FULL_POS - pos_left;
          idx  = offs[5:0];
          if (idb && cmpb) begin
            // no device answered: abort the enumeration
            prev_code = '0;
            active    = 1'b0;
            pos_left  = '0;
            aborts++;
            owe(KIND_DONE, 8'd0, 1'b0, 64'd0, 1'b1);
          end else begin
            // collision: take the 1 branch while it is still unexplored
            if (!idb && !cmpb) begin
              if (mark > pos_left || (prev_code[idx] && mark != pos_left)) begin
                b         = 1'b1;
                next_mark = pos_left;
              end else begin
                b = 1'b0;
              end
            end
            if (b) work_code[idx] = 1'b1;
            pos_left = pos_left - 7'd1;
            owe(KIND_DIR, 8'd0, b, 64'd0, 1'b0);
            // end of a pass
            if (pos_left == 0) begin
              prev_code = work_code;
              mark      = next_mark;
              if (passes != COUNT_MAX) passes++;
              if (work_code[7:0] != 0) begin
                if (found != COUNT_MAX) found++;
                codes++;
                owe(KIND_CODE, 8'd0, 1'b0, work_code, 1'b0);
                if (found >= limit_reg) stop = 1'b1;
              end
              if (next_mark == 0 || passes >= MAX_PASSES_DEF) stop = 1'b1;
              if (stop) begin
                active = 1'b0;
                owe(KIND_DONE, 8'd0, 1'b0, 64'd0, 1'b0);
              end
            end
          end
        end
      end
      if (owed_q.size() > n_before) owed_q[owed_q.size()-1].last = 1'b1;
      return b;
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [87:0] data, logic last);
      search_beat_t w;
      beats++;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: kind %0d, tdata %0h", kind, data);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      check_field("kind", w.kind, kind);
      check_field("command_byte", w.cmd, data[7:0]);
      check_field("direction_bit", w.dir, data[8]);
      check_field("rom_code", w.code, data[72:9]);
      check_field("found_count", w.count, data[80:73]);
      check_field("bus_error", w.err, data[81]);
      check_field("tdata padding", 64'd0, data[87:82]);
      check_field("last_of_run", w.last, last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser;   // [1:0] opcode
  logic [7:0]  s_axis_tdata;   // [0] presence, [1] id_bit, [2] complement_bit
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic [87:0] m_axis_tdata;   // [7:0] cmd, [8] dir, [72:9] code, [80:73] count, [81] err
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  search_scoreboard sb = new();

  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned rcv_hold;
  int unsigned seg_items;
  logic        chosen_dir;

  onewire_rom_search_engine_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one input beat and wait until it is taken
  task automatic send_item(input logic [1:0] op, input logic pres, input logic idb,
                           input logic cmpb);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, cmpb, idb, pres};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chosen_dir = sb.note_input(op, pres, idb, cmpb);
    seg_items++;
  endtask

  // Stop offering and let every owed result drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(reg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Corner cases: ignored opcodes, missing presence, restarts, abort on pair 1,1
  task automatic run_directed();
    send_item(OP_UNUSED, 1'b1, 1'b1, 1'b1);
    send_item(OP_PASS, 1'b1, 1'b0, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
    send_item(OP_BEGIN, 1'b1, 1'b1, 1'b1);
    send_item(OP_PASS, 1'b0, 1'b0, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b1, 1'b0);
    send_item(OP_BEGIN, 1'b0, 1'b0, 1'b0);
    send_item(OP_BEGIN, 1'b0, 1'b0, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
    send_item(OP_PASS, 1'b1, 1'b0, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b1, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b1);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
    send_item(OP_UNUSED, 1'b0, 1'b0, 1'b0);
    send_item(OP_PASS, 1'b1, 1'b1, 1'b1);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
    send_item(OP_BIT, 1'b0, 1'b1, 1'b1);
    send_item(OP_BIT, 1'b0, 1'b0, 1'b0);
  endtask

  // One enumeration over a small simulated bus of devices with related codes
  task automatic run_enumeration();
    logic [63:0] base;
    logic [63:0] dev [4];
    logic [3:0]  part;
    logic        idb, cmpb, pres;
    int unsigned ndev, bitpos, noise;
    base = {$urandom, $urandom};
    ndev = ($urandom_range(15) == 0) ? 0 : $urandom_range(3, 1);
    for (int i = 0; i < 4; i++) begin
      // sparse differences so codes share long prefixes
      dev[i] = base ^ ({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
      if ($urandom_range(3) == 0) dev[i][7:0] = 8'd0;
    end
    send_item(OP_BEGIN, 1'($urandom), 1'($urandom), 1'($urandom));
    while (sb.active && seg_items < SEG_ITEMS) begin
      pres = ($urandom_range(19) != 0);
      send_item(OP_PASS, pres, 1'b0, 1'b0);
      part   = 4'((1 << ndev) - 1);
      bitpos = 0;
      while (sb.active && bitpos < 64) begin
        noise = $urandom_range(199);
        if (noise == 0) begin
          send_item(OP_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom));
        end else if (noise == 1) begin
          // restart the pass in the middle
          send_item(OP_PASS, 1'b1, 1'b0, 1'b0);
          part   = 4'((1 << ndev) - 1);
          bitpos = 0;
        end else begin
          if (noise == 2) begin
            idb  = 1'($urandom);
            cmpb = 1'($urandom);
          end else begin
            idb  = 1'b1;
            cmpb = 1'b1;
            for (int i = 0; i < 4; i++) begin
              if (part[i]) begin
                idb  = idb & dev[i][bitpos];
                cmpb = cmpb & ~dev[i][bitpos];
              end
            end
          end
          send_item(OP_BIT, 1'b0, idb, cmpb);
          for (int i = 0; i < 4; i++) begin
            if (part[i] && dev[i][bitpos] != chosen_dir) part[i] = 1'b0;
          end
          bitpos++;
        end
      end
    end
    // stray beat after the search ended
    if (!sb.active && $urandom_range(3) == 0)
      send_item(2'($urandom_range(3, 1)), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Result receiver: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rcv_hold != 0) begin
        m_axis_tready <= 1'b0;
        rcv_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("onewire_rom_search_engine_top test failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SEARCH_COMMAND;
    cfg_data_i    = '0;
    snd_idle      = 35;
    rcv_idle      = 48;
    rcv_hold      = 0;
    seg_items     = 0;
    chosen_dir    = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg != 0) begin
        wait_idle();
        case (seg)
          1: begin
            write_cfg(REG_SEARCH_COMMAND, 8'h00);
            write_cfg(REG_DEVICE_LIMIT, 8'd0);
          end
          2: begin
            write_cfg(REG_SEARCH_COMMAND, 8'hec);
            write_cfg(REG_DEVICE_LIMIT, 8'd1);
          end
          3: begin
            write_cfg(REG_SEARCH_COMMAND, 8'hff);
            write_cfg(REG_DEVICE_LIMIT, 8'd255);
          end
          4: begin
            write_cfg(REG_SEARCH_COMMAND, 8'hf0);
            write_cfg(REG_DEVICE_LIMIT, 8'd2);
          end
          default: begin
            write_cfg(REG_SEARCH_COMMAND, 8'($urandom));
            write_cfg(REG_DEVICE_LIMIT, 8'($urandom_range(4, 1)));
          end
        endcase
      end
      // idle pattern: receiver-heavy, then sender-heavy, then none
      case (seg / 2)
        0: begin snd_idle = 35; rcv_idle = 48; end
        1: begin snd_idle = 48; rcv_idle = 35; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      // long receiver hold-off so the output queue fills and input stalls
      if (seg == 4) rcv_hold = HOLD_CYC;
      seg_items = 0;
      while (seg_items < SEG_ITEMS) run_enumeration();
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Run covered %0d input beats and %0d result beats: %0d codes found, %0d aborts.",
             sb.items, sb.beats, sb.codes, sb.aborts);
    $display("Six register settings incl. limit 0 and 255, three idle patterns, one long stall.");
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("onewire_rom_search_engine_top test passed");
    end else begin
      $display("onewire_rom_search_engine_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/owsrch_pkg.sv
design/onewire_rom_search_engine_top.sv
tb/tb_onewire_rom_search_engine_top.sv
